FILE: rtl/bcc_pkg.sv
// Package for the button click classifier.
// Holds the payload structs, the configuration struct, register indexes and reset values.
// Used by every module in rtl/.
package bcc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CLICK_TIME      = 2'd0;
	localparam cfg_idx_t REG_LONG_PRESS_TIME = 2'd1;
	localparam cfg_idx_t REG_DEBOUNCE_TIME   = 2'd2;
	localparam cfg_idx_t REG_ACTIVE_LOW      = 2'd3;

	localparam logic [CFG_W-1:0] CLICK_TIME_RST      = 16'd600;
	localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
	localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
	localparam logic             ACTIVE_LOW_RST      = 1'b1;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic click;
		logic double_click;
		logic long_start;
		logic long_during;
		logic long_stop;
		logic long_held;
	} out_t;

	typedef struct packed {
		logic [CFG_W-1:0] click_time;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] debounce_time;
		logic             active_low;
	} cfg_t;

endpackage

FILE: rtl/bcc_fsm.sv
// Click classification state machine: phase, press start time and long-press flag.
// Computes one result per accepted poll from the current state and configuration.
// Depends on bcc_pkg.
module bcc_fsm
	import bcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  in_t  in_data,
	input  cfg_t cfg,
	output out_t result
);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PRESSED  = 3'd1,
		PH_RELEASED = 3'd2,
		PH_SECOND   = 3'd3,
		PH_LONG     = 3'd4
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [TIME_W-1:0] press_start_q;
	logic              long_q, long_d;
	logic              pressed;
	logic [TIME_W-1:0] elapsed;
	logic              lt_debounce, gt_long, gt_click;

	assign pressed = in_data.level ^ cfg.active_low;
	// Timestamps wrap, so the subtraction is taken modulo 2^32.
	assign elapsed     = in_data.now_ms - press_start_q;
	assign lt_debounce = elapsed < {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time};
	assign gt_long     = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time};
	assign gt_click    = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.click_time};

	always_comb begin
		phase_d = phase_q;
		long_d  = long_q;
		result  = '0;
		unique case (phase_q)
			PH_PRESSED: begin
				if (!pressed && lt_debounce) begin
					phase_d = PH_IDLE;
				end else if (!pressed) begin
					phase_d = PH_RELEASED;
				end else if (gt_long) begin
					long_d             = 1'b1;
					result.long_start  = 1'b1;
					result.long_during = 1'b1;
					phase_d            = PH_LONG;
				end
			end
			PH_RELEASED: begin
				// The timeout wins over a second press on the same poll.
				if (gt_click) begin
					result.click = 1'b1;
					phase_d      = PH_IDLE;
				end else if (pressed) begin
					phase_d = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (!pressed) begin
					result.double_click = 1'b1;
					phase_d             = PH_IDLE;
				end
			end
			PH_LONG: begin
				if (!pressed) begin
					long_d           = 1'b0;
					result.long_stop = 1'b1;
					phase_d          = PH_IDLE;
				end else begin
					long_d             = 1'b1;
					result.long_during = 1'b1;
				end
			end
			default: begin
				phase_d = pressed ? PH_PRESSED : PH_IDLE;
			end
		endcase
		result.long_held = long_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			press_start_q <= '0;
			long_q        <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			long_q  <= long_d;
			if ((phase_q != PH_PRESSED) && (phase_q != PH_RELEASED) &&
			    (phase_q != PH_SECOND) && (phase_q != PH_LONG) && pressed) begin
				press_start_q <= in_data.now_ms;
			end
		end
	end

	// The long-press flag is set exactly while the machine sits in the long phase.
	a_long_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		long_q == (phase_q == PH_LONG))
		else $error("long flag out of step with phase");

	// A press seen from idle always records its start time.
	a_press_start_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_IDLE && pressed) |=>
		(press_start_q == $past(in_data.now_ms) && phase_q == PH_PRESSED))
		else $error("press start not captured");

endmodule

FILE: rtl/bcc_out_buf.sv
// Two-entry output register with a skid stage for the result channel.
// Lets a new transaction in while a finished result waits for the receiver.
// Depends on bcc_pkg.
module bcc_out_buf
	import bcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  out_t push_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic main_valid_q, skid_valid_q;
	out_t main_q, skid_q;
	logic push, pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign pop        = main_valid_q && out_ready;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push && !main_valid_q) begin
			main_q <= push_data;
		end
		if (push && main_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without a main entry");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && main_valid_q && !out_ready) |=> (skid_valid_q && skid_q == $past(push_data)))
		else $error("stalled transaction not kept in skid stage");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_valid_q) |=> (main_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output register");

endmodule

FILE: rtl/button_click_classifier.sv
// Top level of the button click classifier.
// Holds the configuration registers and joins bcc_fsm and bcc_out_buf.
// Depends on bcc_pkg.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one transaction per poll, carrying the raw
//     pin level and a free-running millisecond timestamp that may wrap.
//   out channel (out_valid/out_ready/out_data): exactly one result per poll, in order,
//     with click, double click and long-press start/during/stop flags plus the current
//     long-pressed status.
//   cfg port (cfg_we/cfg_index/cfg_wdata): click time, long-press time, debounce time
//     and pin polarity; write only while no poll is in flight.
// A poll's result is registered in the output buffer before it is shown on out_data.
// Throughput: one poll per cycle while in_ready is high. The state update is one
//   32-bit wrapping subtract and three compares, done in the cycle the poll is accepted.
// Stall: a two-entry output buffer keeps in_ready high for one more poll after the
//   receiver stops taking results; in_ready then drops until the backlog clears.
// Reset: arst_n clears the machine to idle, the press time and long flag to zero, the
//   output buffer to empty, and loads the default configuration.
module button_click_classifier
	import bcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	out_t result;
	logic take;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_time      <= CLICK_TIME_RST;
			cfg_q.long_press_time <= LONG_PRESS_TIME_RST;
			cfg_q.debounce_time   <= DEBOUNCE_TIME_RST;
			cfg_q.active_low      <= ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLICK_TIME:      cfg_q.click_time      <= cfg_wdata;
				REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_wdata;
				REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg_wdata;
				REG_ACTIVE_LOW:      cfg_q.active_low      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	bcc_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_data (in_data),
		.cfg     (cfg_q),
		.result  (result)
	);

	bcc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for button_click_classifier: directed polls, then random gestures.
// Holds its own model of the press machine and compares every result with it.
// Depends on bcc_pkg and the RTL under rtl/.
module tb_top;
	import bcc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRESSED,
		ST_RELEASED,
		ST_SECOND,
		ST_LONG
	} btn_phase_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	cfg_idx_t         cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Copy of the configuration as the block should hold it.
	logic [CFG_W-1:0] click_ms    = CLICK_TIME_RST;
	logic [CFG_W-1:0] long_ms     = LONG_PRESS_TIME_RST;
	logic [CFG_W-1:0] debounce_ms = DEBOUNCE_TIME_RST;
	logic             pol_low     = ACTIVE_LOW_RST;

	// Press machine state of the model.
	btn_phase_t        btn_phase   = ST_IDLE;
	logic [TIME_W-1:0] press_ms    = '0;
	logic              long_held_q = 1'b0;

	out_t        predicted_flags [$];
	out_t        oldest;
	int unsigned polls_sent   = 0;
	int unsigned mismatches   = 0;
	int unsigned in_idle_pct  = 0;
	int unsigned out_idle_pct = 0;
	logic [TIME_W-1:0] poll_clock_ms = '0;

	button_click_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// Advances the model by one poll and returns the flags it should produce.
	function automatic out_t classify_poll(input in_t p);
		out_t              r;
		logic              pressed;
		logic [TIME_W-1:0] elapsed;
		r = '0;
		pressed = p.level ^ pol_low;
		elapsed = p.now_ms - press_ms;
		case (btn_phase)
			ST_PRESSED: begin
				if (!pressed && elapsed < {16'd0, debounce_ms}) begin
					btn_phase = ST_IDLE;
				end else if (!pressed) begin
					btn_phase = ST_RELEASED;
				end else if (elapsed > {16'd0, long_ms}) begin
					long_held_q = 1'b1;
					r.long_start = 1'b1;
					r.long_during = 1'b1;
					btn_phase = ST_LONG;
				end
			end
			ST_RELEASED: begin
				// The timeout is checked first, so a press arriving late still ends as a click.
				if (elapsed > {16'd0, click_ms}) begin
					r.click = 1'b1;
					btn_phase = ST_IDLE;
				end else if (pressed) begin
					btn_phase = ST_SECOND;
				end
			end
			ST_SECOND: begin
				if (!pressed) begin
					r.double_click = 1'b1;
					btn_phase = ST_IDLE;
				end
			end
			ST_LONG: begin
				if (!pressed) begin
					long_held_q = 1'b0;
					r.long_stop = 1'b1;
					btn_phase = ST_IDLE;
				end else begin
					r.long_during = 1'b1;
				end
			end
			default: begin
				if (pressed) begin
					btn_phase = ST_PRESSED;
					press_ms = p.now_ms;
				end
			end
		endcase
		r.long_held = long_held_q;
		return r;
	endfunction

	task automatic check_flag(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Predict on input transactions first so a result in the same cycle finds its entry.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predicted_flags.push_back(classify_poll(in_data));
			if (out_valid && out_ready) begin
				if (predicted_flags.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %b", $time, out_data);
					mismatches++;
				end else begin
					oldest = predicted_flags.pop_front();
					check_flag("click", oldest.click, out_data.click);
					check_flag("double_click", oldest.double_click, out_data.double_click);
					check_flag("long_start", oldest.long_start, out_data.long_start);
					check_flag("long_during", oldest.long_during, out_data.long_during);
					check_flag("long_stop", oldest.long_stop, out_data.long_stop);
					check_flag("long_held", oldest.long_held, out_data.long_held);
				end
			end
		end
	end

	task automatic send_poll(input in_t p);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (in_ready !== 1'b1);
		polls_sent++;
	endtask

	// Drops in_valid first, so the last accepted transaction is already in the queue.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_flags.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_CLICK_TIME:      click_ms = val;
			REG_LONG_PRESS_TIME: long_ms = val;
			REG_DEBOUNCE_TIME:   debounce_ms = val;
			REG_ACTIVE_LOW:      pol_low = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] l,
			input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] a);
		wait_idle();
		write_reg(REG_CLICK_TIME, c);
		write_reg(REG_LONG_PRESS_TIME, l);
		write_reg(REG_DEBOUNCE_TIME, d);
		write_reg(REG_ACTIVE_LOW, a);
		cfg_we <= 1'b0;
	endtask

	// Keeps the button in one state for roughly dur_ms, polling at random intervals.
	task automatic hold_button(input logic pressed, input int unsigned dur_ms);
		int unsigned spent;
		int unsigned step;
		in_t         p;
		spent = 0;
		do begin
			step = $urandom_range(dur_ms / 3 + 1, 0);
			poll_clock_ms += step;
			spent += step;
			p.level = pressed ^ pol_low;
			p.now_ms = poll_clock_ms;
			send_poll(p);
		end while (spent < dur_ms);
	endtask

	task automatic play_gesture();
		int unsigned c;
		int unsigned l;
		int unsigned d;
		int unsigned kind;
		in_t         p;
		c = 32'(click_ms);
		l = 32'(long_ms);
		d = 32'(debounce_ms);
		kind = $urandom_range(99);
		// Now and then start just below the wrap point of the timestamp.
		if ($urandom_range(19) == 0)
			poll_clock_ms = 32'hFFFF_FFFF - $urandom_range(l + c, 0);
		if (kind < 15) begin
			repeat ($urandom_range(4, 1)) begin
				if ($urandom_range(1))
					poll_clock_ms = $urandom();
				else
					poll_clock_ms += $urandom_range(64, 0);
				p.level = 1'($urandom_range(1));
				p.now_ms = poll_clock_ms;
				send_poll(p);
			end
		end else if (kind < 30) begin
			hold_button(1'b1, $urandom_range(d, 0));
			hold_button(1'b0, $urandom_range(c + 100, 0));
		end else if (kind < 55) begin
			hold_button(1'b1, $urandom_range(l, d));
			hold_button(1'b0, c + $urandom_range(200, 1));
		end else if (kind < 80) begin
			hold_button(1'b1, $urandom_range(d + c / 3, d));
			hold_button(1'b0, $urandom_range(c / 3, 0));
			hold_button(1'b1, $urandom_range(l, 0));
			hold_button(1'b0, $urandom_range(100, 0));
		end else begin
			hold_button(1'b1, l + $urandom_range(1500, 1));
			hold_button(1'b0, $urandom_range(200, 0));
		end
	endtask

	// Runs on the reset configuration: bounce, click on the timeout edge, double click,
	// long press across the timestamp wrap, and a late second press that still clicks.
	task automatic test_directed_sequence();
		logic              lv [25] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
			1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
			1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		logic [TIME_W-1:0] ts [25] = '{32'd0, 32'd100, 32'd120, 32'd200, 32'd250, 32'd800,
			32'd801, 32'd1000, 32'd1100, 32'd1200, 32'd1300, 32'd1400, 32'hFFFF_FE00,
			32'hFFFF_FFE8, 32'h0000_01E9, 32'h0000_0300, 32'h0000_0400, 32'h0000_1000,
			32'h0000_1100, 32'h0000_1259, 32'h0000_1400, 32'hFFFF_FFFF, 32'h0000_1401,
			32'h0000_1402, 32'h0000_1403};
		in_t               p;
		in_idle_pct = 0;
		out_idle_pct = 0;
		for (int i = 0; i < 25; i++) begin
			p.level = lv[i];
			p.now_ms = ts[i];
			send_poll(p);
		end
		poll_clock_ms = 32'h0000_2000;
	endtask

	// Only bit 0 of the polarity write counts, so this selects active-high.
	task automatic test_register_masking();
		in_t p;
		apply_settings(CLICK_TIME_RST, LONG_PRESS_TIME_RST, DEBOUNCE_TIME_RST, 16'hFFFE);
		p.level = 1'b1;
		p.now_ms = 32'h0000_2000;
		send_poll(p);
		p.level = 1'b0;
		p.now_ms = 32'h0000_2100;
		send_poll(p);
		p.now_ms = 32'h0000_2400;
		send_poll(p);
		poll_clock_ms = 32'h0000_3000;
	endtask

	task automatic test_random_gestures(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] l,
			input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] a,
			input int unsigned snd_pct, input int unsigned rcv_pct, input int unsigned n);
		int unsigned target;
		apply_settings(c, l, d, a);
		in_idle_pct = snd_pct;
		out_idle_pct = rcv_pct;
		target = polls_sent + n;
		while (polls_sent < target)
			play_gesture();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sequence();
		test_register_masking();
		test_random_gestures(CLICK_TIME_RST, LONG_PRESS_TIME_RST, DEBOUNCE_TIME_RST,
			16'd1, 15, 73, 255);
		test_random_gestures(16'd0, 16'd0, 16'd0, 16'd0, 15, 73, 255);
		test_random_gestures(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 73, 15, 255);
		test_random_gestures(CFG_W'($urandom_range(300, 1)), CFG_W'($urandom_range(600, 1)),
			CFG_W'($urandom_range(100, 0)), CFG_W'($urandom_range(1)), 73, 15, 255);
		test_random_gestures(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
			CFG_W'($urandom()), 0, 0, 255);
		test_random_gestures(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 0, 0, 255);
		wait_idle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
